>>> hdl/bfsq_pkg.sv
// Shared types and constants for the Bloom filter name query block.
package bfsq_pkg;

   localparam int unsigned CfgWidth   = 32;
   localparam int unsigned CfgIdxWidth = 1;
   localparam int unsigned FbWidth    = 25;
   localparam logic [31:0] HashMul    = 32'h5bd1e995;
   localparam int unsigned HashShift  = 15;
   localparam logic [24:0] FbReset    = 25'd12500000;
   localparam logic [31:0] SeedReset  = 32'h9747b28c;

   localparam logic                   ReqLoad  = 1'b0;
   localparam logic                   ReqChar  = 1'b1;
   localparam logic [CfgIdxWidth-1:0] CsrFbits = 1'b0;
   localparam logic [CfgIdxWidth-1:0] CsrSeed  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SHR,
      ST_MOD,
      ST_RD,
      ST_TEST,
      ST_OUT
   } state_type;

endpackage

>>> hdl/bloom_filter_string_query.sv
// Top level of the Bloom filter name query block.
//
// Two channels with valid/ready. A req_ word either loads one filter store
// byte (req_type 0) or carries one name character (req_type 1, req_last on
// the final one). Only the last character of a name yields a rsp_ word,
// rsp_present, 1 for maybe present and 0 for definitely absent.
// A load is registered in wr_ff, waddr_ff and wdata_ff before the store
// write. A character runs every hash through one shared multiplier and
// shifter, ST_MUL then ST_SHR for each hash. The last character then
// reduces each hash modulo filter_bits with one shared restoring divider,
// one quotient bit per cycle in ST_MOD, then reads the store through its
// single registered read port (ST_RD, ST_TEST). The block takes one word
// at a time and req_ready is low while it works or while a response waits.
// Reset clears control state and loads the configuration registers with
// FbReset and SeedReset; the filter store is not cleared and must be loaded
// before queries. If the receiver stalls, the response holds on rsp_ and no
// new word is taken. csr_ writes are taken at any edge with csr_we high
// outside reset, but are meant only while the block is idle.
module bloom_filter_string_query
   import bfsq_pkg::*;
#(
   parameter int unsigned HASHES       = 6,
   parameter int unsigned FILTER_BYTES = 2097152
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_type,
   input  logic [20:0]            req_byte_address,
   input  logic [7:0]             req_value,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_present,
   input  logic                   csr_we,
   input  logic [CfgIdxWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]    csr_wdata
);

   localparam int unsigned AW = (FILTER_BYTES > 1) ? $clog2(FILTER_BYTES) : 1;
   localparam int unsigned HW = (HASHES > 1) ? $clog2(HASHES) : 1;

   logic [7:0] store [FILTER_BYTES];

   state_type state_ff, state_in;
   logic [FbWidth-1:0] fbits_ff;
   logic [31:0] seed_ff;
   logic [31:0] hash_ff [HASHES];
   logic mid_ff;
   logic [HW-1:0] hidx_ff, hidx_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0] chr_ff;
   logic last_ff;
   logic [31:0] rem_ff, quo_ff;
   logic [4:0] bit_ff;
   logic all_ff;
   logic [7:0] rd_ff;
   logic [2:0] bsel_ff;
   logic oob_ff;
   logic pres_ff;
   logic wr_ff;
   logic [AW-1:0] waddr_ff;
   logic [7:0] wdata_ff;

   logic accept, hash_last;
   logic [31:0] mod_val, cur_hash;
   logic [32:0] trial;
   logic [31:0] pos;

   assign accept    = req_valid && req_ready;
   assign hash_last = (hidx_ff == HW'(HASHES - 1));
   assign mod_val   = (fbits_ff == '0) ? 32'd1 : {7'd0, fbits_ff};
   assign cur_hash  = hash_ff[hidx_ff];
   assign trial     = {rem_ff, quo_ff[31]} - {1'b0, mod_val};
   assign pos       = rem_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && req_type == ReqChar) state_in = ST_MUL;
         ST_MUL:  state_in = ST_SHR;
         ST_SHR: begin
            if (!hash_last) state_in = ST_MUL;
            else if (last_ff) state_in = ST_MOD;
            else state_in = ST_IDLE;
         end
         ST_MOD:  if (bit_ff == 5'd31) state_in = ST_RD;
         ST_RD:   state_in = ST_TEST;
         ST_TEST: state_in = hash_last ? ST_OUT : ST_MOD;
         ST_OUT:  if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      hidx_in = hidx_ff;
      acc_in  = acc_ff;
      unique case (state_ff)
         ST_IDLE: hidx_in = '0;
         ST_MUL: begin
            acc_in = ((mid_ff ? cur_hash : seed_ff + 32'(hidx_ff)) ^ {24'd0, chr_ff})
                     * HashMul;
         end
         ST_SHR:  hidx_in = hash_last ? '0 : hidx_ff + 1'b1;
         ST_TEST: hidx_in = hidx_ff + 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == ST_IDLE) && !wr_ff;
      rsp_valid   = (state_ff == ST_OUT);
      rsp_present = pres_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fbits_ff <= FbReset;
         seed_ff  <= SeedReset;
         mid_ff   <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == CsrFbits) fbits_ff <= csr_wdata[FbWidth-1:0];
         if (csr_we && csr_index == CsrSeed) seed_ff <= csr_wdata;
         wr_ff <= accept && req_type == ReqLoad
                  && {11'd0, req_byte_address} < 32'(FILTER_BYTES);
         if (state_ff == ST_SHR && hash_last) mid_ff <= !last_ff;
      end
   end

   always_ff @(posedge clock) begin
      hidx_ff <= hidx_in;
      acc_ff  <= acc_in;
      if (accept) begin
         chr_ff   <= req_value;
         last_ff  <= req_last;
         waddr_ff <= AW'(req_byte_address);
         wdata_ff <= req_value;
         all_ff   <= 1'b1;
      end
      if (state_ff == ST_SHR) begin
         hash_ff[hidx_ff] <= acc_ff ^ (acc_ff >> HashShift);
      end
      if ((state_ff == ST_SHR && hash_last) || state_ff == ST_TEST) begin
         rem_ff <= '0;
         quo_ff <= (state_ff == ST_TEST) ? hash_ff[hidx_ff + 1'b1]
                   : (HASHES == 1) ? acc_ff ^ (acc_ff >> HashShift) : hash_ff[0];
         bit_ff <= '0;
      end else if (state_ff == ST_MOD) begin
         rem_ff <= trial[32] ? {rem_ff[30:0], quo_ff[31]} : trial[31:0];
         quo_ff <= {quo_ff[30:0], 1'b0};
         bit_ff <= bit_ff + 5'd1;
      end
      if (state_ff == ST_RD) begin
         bsel_ff <= pos[2:0];
         oob_ff  <= (pos >> 3) >= 32'(FILTER_BYTES);
      end
      if (state_ff == ST_TEST) begin
         all_ff <= all_ff && !oob_ff && rd_ff[bsel_ff];
         pres_ff <= all_ff && !oob_ff && rd_ff[bsel_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ff) store[waddr_ff] <= wdata_ff;
      rd_ff <= store[pos[AW+2:3]];
   end

endmodule

>>> hdl/bfsq_checker.sv
// Port-level checks for the Bloom filter name query block.
module bfsq_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_present
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_present))
      else $error("response dropped while stalled");

   a_no_take_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("word taken while response pending");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_after_take: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_ready)
      else $error("response rose with block ready");

endmodule

bind bloom_filter_string_query bfsq_checker u_bfsq_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_present(rsp_present)
);

>>> sim/bloom_filter_string_query_tb.sv
// Testbench for the Bloom filter name query block against a shadow filter.
module bloom_filter_string_query_tb
   import bfsq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NumHashes  = 6;
   localparam int unsigned StoreBytes = 2097152;
   localparam int unsigned LoadSpan   = 256;
   localparam int          HoldCycles = 400;
   localparam longint      CycleLimit = 3000000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_type;
   logic [20:0]            req_byte_address;
   logic [7:0]             req_value;
   logic                   req_last;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_present;
   logic                   csr_we;
   logic [CfgIdxWidth-1:0] csr_index;
   logic [CfgWidth-1:0]    csr_wdata;

   bloom_filter_string_query uut (.*);

   logic [24:0] shadow_fbits;
   logic [31:0] shadow_seed;
   logic [31:0] name_hash [NumHashes];
   logic        in_name;
   logic [7:0]  shadow_store [logic [20:0]];
   logic        present_queue [$];
   int          fail_count = 0;
   longint      cycle_count = 0;
   bit          long_hold = 1'b0;
   int          hold_count;
   int          stall_mode;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAIL bloom_filter_string_query");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_count <= 0;
      end else if (long_hold && hold_count < HoldCycles) begin
         hold_count <= hold_count + 1;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(3, 0) != 0);
            default: rsp_ready <= cycle_count[2];
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (present_queue.size() == 0) begin
            $error("unexpected word: present=%0b", rsp_present);
            fail_count++;
         end else begin
            if (rsp_present !== present_queue[0]) begin
               $error("present: expected %0b actual %0b", present_queue[0], rsp_present);
               fail_count++;
            end
            void'(present_queue.pop_front());
         end
      end
   end

   function automatic logic [31:0] mix_byte(logic [31:0] h, logic [7:0] c);
      logic [31:0] m;
      m = (h ^ {24'd0, c}) * HashMul;
      return m ^ (m >> HashShift);
   endfunction

   function automatic logic read_bit(logic [31:0] pos);
      logic [31:0] addr;
      addr = pos >> 3;
      if (addr >= StoreBytes) return 1'b0;
      if (!shadow_store.exists(addr[20:0])) return 1'b0;
      return shadow_store[addr[20:0]][pos[2:0]];
   endfunction

   function automatic void predict_word(logic t, logic [20:0] a, logic [7:0] v, logic l);
      logic [31:0] modulus;
      logic        all_set;
      if (t == ReqLoad) begin
         shadow_store[a] = v;
         return;
      end
      if (!in_name)
         for (int i = 0; i < NumHashes; i++) name_hash[i] = shadow_seed + i;
      for (int i = 0; i < NumHashes; i++) name_hash[i] = mix_byte(name_hash[i], v);
      if (!l) begin
         in_name = 1'b1;
         return;
      end
      modulus = (shadow_fbits == 0) ? 32'd1 : {7'd0, shadow_fbits};
      all_set = 1'b1;
      for (int i = 0; i < NumHashes; i++)
         if (!read_bit(name_hash[i] % modulus)) all_set = 1'b0;
      in_name = 1'b0;
      present_queue.push_back(all_set);
   endfunction

   task automatic send_word(logic t, logic [20:0] a, logic [7:0] v, logic l, bit gaps);
      if (gaps && $urandom_range(7, 0) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= t;
      req_byte_address <= a;
      req_value <= v;
      req_last <= l;
      do @(posedge clock); while (!req_ready);
      predict_word(t, a, v, l);
   endtask

   task automatic cover_name(logic [7:0] v, bit gaps);
      logic [31:0] h;
      logic [31:0] modulus;
      logic [31:0] addr;
      modulus = (shadow_fbits == 0) ? 32'd1 : {7'd0, shadow_fbits};
      for (int i = 0; i < NumHashes; i++) begin
         h = in_name ? name_hash[i] : shadow_seed + i;
         h = mix_byte(h, v);
         addr = (h % modulus) >> 3;
         if (addr < StoreBytes && !shadow_store.exists(addr[20:0]))
            send_word(ReqLoad, addr[20:0], 8'($urandom), 1'b0, gaps);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (present_queue.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(logic [CfgIdxWidth-1:0] idx, logic [31:0] data);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CsrFbits) shadow_fbits = data[24:0];
      else shadow_seed = data;
   endtask

   task automatic send_name(int len, bit gaps);
      logic [7:0] c;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(15, 0) == 0)
            send_word(ReqLoad, 21'($urandom_range(LoadSpan - 1, 0)), 8'($urandom), 1'b0, gaps);
         c = 8'($urandom);
         if (i == len - 1) cover_name(c, gaps);
         send_word(ReqChar, 21'($urandom), c, (i == len - 1), gaps);
      end
   endtask

   task automatic fill_span();
      for (int a = 0; a < LoadSpan; a++)
         send_word(ReqLoad, 21'(a), ($urandom_range(1, 0) ? 8'hff : 8'($urandom)), 1'b0, 1'b0);
   endtask

   task automatic test_directed();
      fill_span();
      send_word(ReqLoad, 21'h1fffff, 8'hff, 1'b0, 1'b0);
      send_word(ReqLoad, 21'd0, 8'hff, 1'b0, 1'b0);
      write_csr(CsrFbits, 32'd1);
      send_word(ReqChar, 21'h1fffff, 8'h00, 1'b1, 1'b0);
      write_csr(CsrFbits, 32'd0);
      send_word(ReqChar, 21'd0, 8'hff, 1'b1, 1'b0);
      write_csr(CsrFbits, 32'h1ffffff);
      write_csr(CsrSeed, 32'hffffffff);
      send_word(ReqChar, 21'd0, 8'h55, 1'b0, 1'b0);
      send_word(ReqLoad, 21'd5, 8'hff, 1'b0, 1'b0);
      cover_name(8'haa, 1'b0);
      send_word(ReqChar, 21'd0, 8'haa, 1'b1, 1'b0);
      write_csr(CsrFbits, 32'd16777216);
      write_csr(CsrSeed, 32'd0);
      send_name(3, 0);
      write_csr(CsrFbits, 32'(LoadSpan * 8));
   endtask

   task automatic test_random(int words);
      int sent;
      sent = 0;
      while (sent < words) begin
         int len;
         len = $urandom_range(6, 1);
         send_name(len, 1'b1);
         sent += len;
         if ($urandom_range(99, 0) == 0) begin
            write_csr(CsrSeed, $urandom);
            write_csr(CsrFbits, $urandom_range(LoadSpan * 8, 1));
            stall_mode = $urandom_range(2, 0);
         end
      end
   endtask

   task automatic test_backpressure();
      long_hold = 1'b1;
      repeat (2) @(posedge clock);
      send_name(2, 1'b0);
      send_name(2, 1'b0);
      send_name(2, 1'b0);
   endtask

   initial begin
      stall_mode = 1;
      in_name = 1'b0;
      shadow_fbits = FbReset;
      shadow_seed = SeedReset;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = ReqLoad;
      req_byte_address = '0;
      req_value = '0;
      req_last = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(950);
      drain();
      if (fail_count == 0) $display("PASS bloom_filter_string_query");
      else $display("FAIL bloom_filter_string_query");
      $finish;
   end
endmodule
